/* design/blist_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package blist_pkg;

  // Request codes as they arrive on the input tuser field.
  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_FIND   = 2'd2
  } req_code_t;

  localparam int KEY_W  = 8;
  localparam int POS_W  = 8;
  localparam int LEN_W  = 9;
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  // A classified request as it waits in the queue between front and back.
  // An unused request code leaves all three flags low.
  typedef struct packed {
    logic              is_append;
    logic              is_remove;
    logic              is_find;
    logic [KEY_W-1:0]  key;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic              full_res;
    logic [LEN_W-1:0]  length;
    logic [POS_W-1:0]  position;
    logic              found;
  } result_t;

endpackage

`default_nettype wire

/* design/blist_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module blist_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/blist_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module blist_front
  import blist_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       req_type,
  input  wire logic [KEY_W-1:0] key,
  output logic                  q_valid,
  input  wire logic             q_ready,
  output cmd_t                  q_cmd
);

  cmd_t           slot [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   fill;
  cmd_t           cmd_in;
  logic           push;
  logic           pop;

  // Decode the request code into one flag per operation.
  always_comb begin
    cmd_in           = '0;
    cmd_in.key       = key;
    case (req_type)
      REQ_APPEND: cmd_in.is_append = 1'b1;
      REQ_REMOVE: cmd_in.is_remove = 1'b1;
      REQ_FIND:   cmd_in.is_find   = 1'b1;
      default:    cmd_in           = cmd_in;
    endcase
  end

  assign in_ready = (fill != (QAW+1)'(QDEPTH));
  assign q_valid  = (fill != '0);
  assign q_cmd    = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

/* design/blist_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module blist_back
  import blist_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  output logic      q_ready,
  input  wire cmd_t q_cmd,
  output logic      out_valid,
  input  wire logic out_ready,
  output result_t   out_res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t          state, state_next;
  cmd_t            cmd, cmd_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   rd_idx, rd_idx_next;
  logic [CW-1:0]   kept, kept_next;
  logic            pend, pend_next;
  logic [AW-1:0]   pend_idx, pend_idx_next;
  logic            found, found_next;
  logic [AW-1:0]   pos, pos_next;
  logic            full, full_next;
  logic            out_valid_next;
  result_t         out_res_next;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [KEY_W-1:0] ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [KEY_W-1:0] ram_rdata;
  logic            match;

  blist_ram #(
    .WIDTH(KEY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign match = (ram_rdata == cmd.key);

  always_comb begin
    state_next     = state;
    cmd_next       = cmd;
    count_next     = count;
    rd_idx_next    = rd_idx;
    kept_next      = kept;
    pend_next      = pend;
    pend_idx_next  = pend_idx;
    found_next     = found;
    pos_next       = pos;
    full_next      = full;
    out_valid_next = out_valid;
    out_res_next   = out_res;
    q_ready        = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = count[AW-1:0];
    ram_wdata      = cmd.key;
    ram_raddr      = rd_idx[AW-1:0];

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (q_valid && !out_valid) begin
          q_ready     = 1'b1;
          cmd_next    = q_cmd;
          found_next  = 1'b0;
          pos_next    = '0;
          full_next   = 1'b0;
          rd_idx_next = '0;
          kept_next   = '0;
          pend_next   = 1'b0;
          if (q_cmd.is_append) begin
            if (count >= CW'(CAPACITY)) begin
              full_next = 1'b1;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = count[AW-1:0];
              ram_wdata  = q_cmd.key;
              count_next = count + 1'b1;
            end
            state_next = ST_DONE;
          end else if (q_cmd.is_remove || q_cmd.is_find) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        // Issue one read per cycle; the data comes back in the next cycle.
        if (rd_idx != count) begin
          rd_idx_next   = rd_idx + 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = rd_idx[AW-1:0];
        end else begin
          pend_next = 1'b0;
        end
        if (pend) begin
          if (cmd.is_find) begin
            if (match) begin
              found_next = 1'b1;
              pos_next   = pend_idx;
              pend_next  = 1'b0;
              state_next = ST_DONE;
            end
          end else if (!match) begin
            // Compaction writes never pass the read pointer.
            ram_we    = 1'b1;
            ram_waddr = kept[AW-1:0];
            ram_wdata = ram_rdata;
            kept_next = kept + 1'b1;
          end
        end
        if ((rd_idx == count) && !pend) begin
          if (cmd.is_remove) begin
            count_next = kept;
          end
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid_next        = 1'b1;
        out_res_next.found    = found;
        out_res_next.position = POS_W'(pos);
        out_res_next.length   = LEN_W'(count);
        out_res_next.full_res = full;
        state_next            = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd      <= cmd_next;
    rd_idx   <= rd_idx_next;
    kept     <= kept_next;
    pend_idx <= pend_idx_next;
    found    <= found_next;
    pos      <= pos_next;
    full     <= full_next;
    out_res  <= out_res_next;
  end

endmodule

`default_nettype wire

/* design/byte_list_append_remove_find.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-----------------------------------------
// s_*      | in        | s_tvalid, s_tready | s_tdata: key; s_tuser: req_type
// m_*      | out       | m_tvalid, m_tready | m_tdata: found, position, length, full_res
//
// An append passes through the request queue and the idle and done states before its
// result is registered. A find or a remove walks the stored entries through the list
// memory's single read port, one entry per cycle, up to CAPACITY entries.
// Reset (rst, synchronous) empties the list and the request queue; the memory
// contents are left as they are and need no clearing pass.
// A two-entry request queue accepts up to two requests while a result waits on m_tready.

module byte_list_append_remove_find
  import blist_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] key
  input  wire logic [1:0]  s_tuser,   // [1:0] req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata    // [0] found, [8:1] position, [17:9] length,
                                      // [18] full_res, [23:19] zero
);

  logic    q_valid;
  logic    q_ready;
  cmd_t    q_cmd;
  result_t res;

  // The front end classifies each request and holds it until the
  // sequencer is free.
  blist_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .req_type(s_tuser),
    .key     (s_tdata),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_cmd   (q_cmd)
  );

  // The back end owns the list memory and the entry count, carries out
  // one request at a time and holds its result in an output register.
  blist_back #(
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_res  (res)
  );

  // The result struct is declared lowest field last, so it packs directly.
  assign m_tdata = {5'b0, res};

endmodule

`default_nettype wire

/* design/blist_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module blist_checker #(
  parameter int CAPACITY = 256
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [7:0]  s_tdata,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);

  // A result waiting for the sink must not change or vanish.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // No result is left pending after reset.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A match and a rejected append never appear together.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[18]))
    else $error("found and full_res both set");

  // A miss always reports position zero.
  a_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[8:1] == 8'd0)
    else $error("position nonzero without a match");

  // A rejected append means the list is at capacity.
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[18] |-> m_tdata[17:9] == 9'(CAPACITY))
    else $error("full_res with list below capacity");

endmodule

bind byte_list_append_remove_find blist_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

`default_nettype wire
